// ----- sv/fac_pkg.sv -----
`timescale 1ns / 1ps
// fac_pkg: shared types and codes for the fit block allocator
// word structs, scan token flags, policy and register codes; no dependencies

package fac_pkg;

  // fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // configuration register indexes
  localparam logic CFG_FIT_POLICY  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam int CFG_DATA_W = 5;
  localparam int SLOT_W     = 4;
  localparam int SIZE_W     = 24;

  typedef struct packed {
    logic              req_type;
    logic [SLOT_W-1:0] block_slot;
    logic [SIZE_W-1:0] size_value;
  } fac_in_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] chosen_block;
    logic [SIZE_W-1:0] space_left;
  } fac_out_t;

  // flags of the search token that walks the cell row
  typedef struct packed {
    logic go;      // token present at this hop
    logic hit;     // main candidate found
    logic lo_hit;  // next fit: candidate below the start pointer found
  } fac_flag_t;

endpackage

// ----- sv/fac_cell.sv -----
`timescale 1ns / 1ps
// fac_cell: one table entry plus one registered hop of the search token
// depends on fac_pkg

module fac_cell #(
  parameter int SIZE_BITS = 24,
  parameter int IW        = 4,
  parameter int CW        = 5,
  parameter int J         = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // broadcast from the controller
  input  logic [1:0]            policy,
  input  logic [SIZE_BITS-1:0]  req_sz,
  input  logic [IW-1:0]         start_idx,
  input  logic [CW-1:0]         count,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_idx,
  input  logic [SIZE_BITS-1:0]  wr_data,
  // token from the left neighbor
  input  fac_pkg::fac_flag_t    flag_i,
  input  logic [IW-1:0]         idx_i,
  input  logic [SIZE_BITS-1:0]  sz_i,
  input  logic [IW-1:0]         lo_idx_i,
  input  logic [SIZE_BITS-1:0]  lo_sz_i,
  // token to the right neighbor
  output fac_pkg::fac_flag_t    flag_o,
  output logic [IW-1:0]         idx_o,
  output logic [SIZE_BITS-1:0]  sz_o,
  output logic [IW-1:0]         lo_idx_o,
  output logic [SIZE_BITS-1:0]  lo_sz_o
);

  localparam logic [IW-1:0] J_IDX = IW'(J);
  localparam logic [31:0]   J_W   = 32'(J);

  logic [SIZE_BITS-1:0] size_r;
  logic                 go_r;
  logic                 hit_r;
  logic                 lo_hit_r;
  logic [IW-1:0]        idx_r;
  logic [SIZE_BITS-1:0] sz_r;
  logic [IW-1:0]        lo_idx_r;
  logic [SIZE_BITS-1:0] lo_sz_r;

  logic fits;
  logic upper;
  logic take_hi;
  logic take_lo;

  always_comb begin
    fits    = (32'(count) > J_W) && (size_r >= req_sz);
    upper   = (policy != fac_pkg::POL_NEXT) || (J_IDX >= start_idx);
    take_hi = fits && upper &&
              (!flag_i.hit ||
               ((policy == fac_pkg::POL_BEST)  && (size_r < sz_i)) ||
               ((policy == fac_pkg::POL_WORST) && (size_r > sz_i)));
    take_lo = fits && !upper && !flag_i.lo_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else if (wr_en && (wr_idx == J_IDX)) begin
      size_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= flag_i.go;
    end
  end

  always_ff @(posedge clk) begin
    hit_r    <= flag_i.hit || take_hi;
    lo_hit_r <= flag_i.lo_hit || take_lo;
    idx_r    <= take_hi ? J_IDX : idx_i;
    sz_r     <= take_hi ? size_r : sz_i;
    lo_idx_r <= take_lo ? J_IDX : lo_idx_i;
    lo_sz_r  <= take_lo ? size_r : lo_sz_i;
  end

  assign flag_o.go     = go_r;
  assign flag_o.hit    = hit_r;
  assign flag_o.lo_hit = lo_hit_r;
  assign idx_o         = idx_r;
  assign sz_o          = sz_r;
  assign lo_idx_o      = lo_idx_r;
  assign lo_sz_o       = lo_sz_r;

endmodule

// ----- sv/fit_block_allocator_top.sv -----
`timescale 1ns / 1ps
// fit_block_allocator_top: controller, config registers and the row of fac_cell
// depends on fac_pkg and fac_cell

// Block size allocator. The table of BLOCKS remaining sizes lives in a row of
// cells, one entry per cell. A load word writes one entry and is accepted even
// while an earlier result still waits at the output. An allocate word sends a
// search token along the cell row, one cell per cycle, each cell folding its
// entry into the candidate under the configured policy (first, best, worst or
// next fit). An allocate passes through these steps from acceptance to the next
// acceptance: launch the token into the first cell, hop through the rest of the
// row, resolve, write back the reduced size on a grant and load the result word
// (held while the output register is not free), then return to idle before the
// next word is taken. in_stall is high while a search is in flight or while a
// finished result cannot yet enter the output register.

module fit_block_allocator_top #(
  parameter int BLOCKS    = 16,
  parameter int SIZE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fac_pkg::fac_in_t                in_word,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output fac_pkg::fac_out_t               out_word,
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [fac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CW = $clog2(BLOCKS + 1);
  localparam logic [31:0] BLOCKS_W = 32'(BLOCKS);

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           fit_policy_r;
  logic [4:0]           block_count_r;
  logic [IW-1:0]        next_ptr_r;
  logic [SIZE_BITS-1:0] req_sz_r;
  logic [IW-1:0]        start_r;
  logic [CW-1:0]        count_r;
  logic                 res_hit_r;
  logic [IW-1:0]        res_idx_r;
  logic [SIZE_BITS-1:0] res_sz_r;
  logic                 out_valid_r;
  fac_pkg::fac_out_t    out_word_r;

  // token chain, element 0 driven by the controller
  fac_pkg::fac_flag_t   flag_c   [0:BLOCKS];
  logic [IW-1:0]        idx_c    [0:BLOCKS];
  logic [SIZE_BITS-1:0] sz_c     [0:BLOCKS];
  logic [IW-1:0]        lo_idx_c [0:BLOCKS];
  logic [SIZE_BITS-1:0] lo_sz_c  [0:BLOCKS];
  logic [BLOCKS:0]      go_vec;

  logic                 in_fire;
  logic                 out_free;
  logic                 grant_wr;
  logic [CW-1:0]        used_cnt;
  logic [IW-1:0]        start_nxt;
  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 fin_hit;
  logic [IW-1:0]        fin_idx;
  logic [SIZE_BITS-1:0] fin_sz;
  fac_pkg::fac_flag_t   last_flag;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_flag = flag_c[BLOCKS];

  // blocks in use, clamped to the table size
  always_comb begin
    used_cnt  = (32'(block_count_r) > BLOCKS_W) ? CW'(BLOCKS) : CW'(block_count_r);
    start_nxt = (32'(next_ptr_r) < 32'(used_cnt)) ? next_ptr_r : '0;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r  <= fac_pkg::POL_FIRST;
      block_count_r <= 5'd16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fac_pkg::CFG_FIT_POLICY:  fit_policy_r  <= cfg_data[1:0];
        fac_pkg::CFG_BLOCK_COUNT: block_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_word.req_type == fac_pkg::REQ_ALLOC)) state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (last_flag.go) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request latch at acceptance of an allocate
  always_ff @(posedge clk) begin
    if (in_fire && (in_word.req_type == fac_pkg::REQ_ALLOC)) begin
      req_sz_r <= SIZE_BITS'(in_word.size_value);
      start_r  <= start_nxt;
      count_r  <= used_cnt;
    end
  end

  // resolve the token leaving the last cell
  always_comb begin
    fin_hit = last_flag.hit;
    fin_idx = idx_c[BLOCKS];
    fin_sz  = sz_c[BLOCKS];
    if ((fit_policy_r == fac_pkg::POL_NEXT) && !last_flag.hit) begin
      // nothing at or after the pointer: wrap to the low part of the table
      fin_hit = last_flag.lo_hit;
      fin_idx = lo_idx_c[BLOCKS];
      fin_sz  = lo_sz_c[BLOCKS];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && last_flag.go) begin
      res_hit_r <= fin_hit;
      res_idx_r <= fin_idx;
      res_sz_r  <= fin_sz;
    end
  end

  // table write: load word or write back of a grant
  assign grant_wr = (state_r == ST_DONE) && out_free && res_hit_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = res_idx_r;
    wr_data = res_sz_r - req_sz_r;
    if (grant_wr) begin
      wr_en = 1'b1;
    end else if (in_fire && (in_word.req_type == fac_pkg::REQ_LOAD)) begin
      // slots past the table are dropped
      wr_en   = (32'(in_word.block_slot) < BLOCKS_W);
      wr_idx  = IW'(in_word.block_slot);
      wr_data = SIZE_BITS'(in_word.size_value);
    end
  end

  // next fit pointer follows every grant
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ptr_r <= '0;
    end else if (grant_wr) begin
      next_ptr_r <= res_idx_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_word_r.granted      <= res_hit_r;
      out_word_r.chosen_block <= res_hit_r ? fac_pkg::SLOT_W'(res_idx_r) : '0;
      out_word_r.space_left   <= res_hit_r ? fac_pkg::SIZE_W'(res_sz_r - req_sz_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // token launch into the first cell
  assign flag_c[0].go     = (state_r == ST_LAUNCH);
  assign flag_c[0].hit    = 1'b0;
  assign flag_c[0].lo_hit = 1'b0;
  assign idx_c[0]         = '0;
  assign sz_c[0]          = '0;
  assign lo_idx_c[0]      = '0;
  assign lo_sz_c[0]       = '0;
  assign go_vec[0]        = flag_c[0].go;

  // cell row
  for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
    fac_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IW        (IW),
      .CW        (CW),
      .J         (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .policy    (fit_policy_r),
      .req_sz    (req_sz_r),
      .start_idx (start_r),
      .count     (count_r),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .flag_i    (flag_c[g]),
      .idx_i     (idx_c[g]),
      .sz_i      (sz_c[g]),
      .lo_idx_i  (lo_idx_c[g]),
      .lo_sz_i   (lo_sz_c[g]),
      .flag_o    (flag_c[g+1]),
      .idx_o     (idx_c[g+1]),
      .sz_o      (sz_c[g+1]),
      .lo_idx_o  (lo_idx_c[g+1]),
      .lo_sz_o   (lo_sz_c[g+1])
    );
    assign go_vec[g+1] = flag_c[g+1].go;
  end

  // at most one search token in the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(go_vec) <= 1)
    else $error("more than one search token in the cell row");

  // the token leaves the row only while the controller waits for it
  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    last_flag.go |-> (state_r == ST_SCAN))
    else $error("search token left the row outside a scan");

  // a granted block lies within the blocks in use and holds the request
  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_hit_r) |->
      ((32'(res_idx_r) < 32'(count_r)) && (res_sz_r >= req_sz_r)))
    else $error("grant outside the table in use or too small");

  // a refused request reports zero block and zero space
  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.granted) |->
      ((out_word_r.chosen_block == '0) && (out_word_r.space_left == '0)))
    else $error("refused result carries nonzero fields");

endmodule

// ----- tb/sv/fit_block_allocator_checker.sv -----
`timescale 1ns / 1ps
// fit_block_allocator_checker: watches the word and config ports of the allocator,
// keeps its own size table and grant queue; depends on fac_pkg

module fit_block_allocator_checker #(
  parameter int BLOCKS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  fac_pkg::fac_in_t                in_word,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  fac_pkg::fac_out_t               out_word,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [fac_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              grants_owed
);
  import fac_pkg::*;

  logic [SIZE_W-1:0] size_table [BLOCKS];
  logic [SLOT_W-1:0] last_grant;
  logic [1:0]        policy_reg;
  logic [4:0]        count_reg;
  fac_out_t          grant_queue [$];

  // serve one request from the table, updating it as the block would
  function automatic fac_out_t serve_request(input logic [SIZE_W-1:0] want);
    fac_out_t res;
    int       used;
    int       idx;
    int       pick;
    bit       found;
    used  = (count_reg > BLOCKS) ? BLOCKS : count_reg;
    found = 1'b0;
    pick  = 0;
    res   = '0;
    if (policy_reg == POL_NEXT) begin
      idx = (last_grant < used) ? last_grant : 0;
      for (int k = 0; k < used && !found; k++) begin
        if (size_table[idx] >= want) begin
          pick  = idx;
          found = 1'b1;
        end else begin
          idx = (idx + 1 < used) ? idx + 1 : 0;
        end
      end
    end else begin
      // first fit keeps its first pick; best and worst refine it, lower index on ties
      for (int j = 0; j < used; j++) begin
        if (size_table[j] >= want) begin
          if (!found) begin
            pick  = j;
            found = 1'b1;
          end else if (policy_reg == POL_BEST && size_table[j] < size_table[pick]) begin
            pick = j;
          end else if (policy_reg == POL_WORST && size_table[j] > size_table[pick]) begin
            pick = j;
          end
        end
      end
    end
    if (found) begin
      size_table[pick] = size_table[pick] - want;
      last_grant       = pick[SLOT_W-1:0];
      res.granted      = 1'b1;
      res.chosen_block = pick[SLOT_W-1:0];
      res.space_left   = size_table[pick];
    end
    return res;
  endfunction

  assign grants_owed = grant_queue.size();

  always @(posedge clk) begin
    fac_out_t want_word;
    if (!rst_n) begin
      foreach (size_table[i]) size_table[i] = '0;
      last_grant     = '0;
      policy_reg     = POL_FIRST;
      count_reg      = 5'd16;
      mismatch_count = 0;
      grant_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_FIT_POLICY) policy_reg = cfg_data[1:0];
        else count_reg = cfg_data[4:0];
      end
      // results first: a word accepted now cannot stem from an input of this edge
      if (out_valid && !out_stall) begin
        if (grant_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t unexpected result word: granted %0b block %0d space %0d", $realtime,
                     out_word.granted, out_word.chosen_block, out_word.space_left);
        end else begin
          want_word = grant_queue.pop_front();
          if (out_word.granted !== want_word.granted ||
              out_word.chosen_block !== want_word.chosen_block ||
              out_word.space_left !== want_word.space_left) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t mismatch: expected %0b/%0d/%0d got %0b/%0d/%0d", $realtime,
                       want_word.granted, want_word.chosen_block, want_word.space_left,
                       out_word.granted, out_word.chosen_block, out_word.space_left);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_word.req_type == REQ_LOAD) begin
          if (in_word.block_slot < BLOCKS) size_table[in_word.block_slot] = in_word.size_value;
        end else begin
          grant_queue.push_back(serve_request(in_word.size_value));
        end
      end
    end
  end

endmodule

// ----- tb/sv/fit_block_allocator_top_test.sv -----
`timescale 1ns / 1ps
// fit_block_allocator_top_test: stimulus, idling and verdict for the allocator
// depends on fac_pkg, fit_block_allocator_top and fit_block_allocator_checker

module fit_block_allocator_top_test;
  import fac_pkg::*;

  localparam int BLOCKS      = 16;
  localparam int SETTLE      = BLOCKS + 16;  // covers one full search plus write-back
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  fac_in_t               in_word;
  logic                  out_valid;
  logic                  out_stall;
  fac_out_t              out_word;
  logic                  cfg_wr_en;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int grants_owed;
  int cycle_count;
  bit gaps_on;        // random idling on both sides for the current phase
  bit hold_request;   // asks the pressure process for one long receiver hold
  logic long_hold;

  fit_block_allocator_top #(.BLOCKS(BLOCKS), .SIZE_BITS(SIZE_W)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fit_block_allocator_checker #(.BLOCKS(BLOCKS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .grants_owed    (grants_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: the slowest legal run is far below this
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[fit_block_allocator_top] ERROR");
      $finish;
    end
  end

  // long receiver hold, counted here so the sender keeps offering words meanwhile
  initial begin
    long_hold = 1'b0;
    wait (hold_request);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  // receiver: after each accepted result word draw a random stall run while gaps are on
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold || stall_left > 0) begin
        out_stall <= 1'b1;
        if (stall_left > 0) stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) stall_left = gaps_on ? $urandom_range(0, 12) : 0;
    end
  end

  // offer one word after an optional gap and hold it until accepted;
  // returns on the falling edge after acceptance
  task automatic send_word(input fac_in_t w);
    int gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [SIZE_W-1:0] size);
    fac_in_t w;
    w.req_type   = REQ_LOAD;
    w.block_slot = slot;
    w.size_value = size;
    send_word(w);
  endtask

  task automatic send_alloc(input logic [SIZE_W-1:0] size);
    fac_in_t w;
    w.req_type   = REQ_ALLOC;
    w.block_slot = SLOT_W'($urandom_range(0, BLOCKS - 1));  // don't care bits still toggle
    w.size_value = size;
    send_word(w);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // drain all owed results, let a trailing load settle, then change the setup
  task automatic reconfigure(input logic [1:0] policy, input logic [4:0] count);
    in_valid <= 1'b0;
    do @(posedge clk); while (grants_owed != 0);
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_FIT_POLICY, {3'b000, policy});
    write_reg(CFG_BLOCK_COUNT, count);
  endtask

  // sizes lean small so that requests often fit, with extremes and full-width values
  function automatic logic [SIZE_W-1:0] draw_size(input bit roomy);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return SIZE_W'($urandom_range(0, roomy ? 4096 : 64));
      5:       return SIZE_W'($urandom_range(0, 255));
      default: return SIZE_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [4:0] count;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_FIT_POLICY;
    cfg_data     = '0;
    gaps_on      = 1'b0;
    hold_request = 1'b0;
    cycle_count  = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset setup is first fit over all blocks; empty table takes only a zero request
    send_alloc('0);
    send_alloc(24'd1);
    send_load(4'd15, '1);
    send_load(4'd3, 24'd10);
    send_load(4'd7, 24'd10);
    send_load(4'd9, 24'd4);
    send_alloc('1);          // only the full-size block fits, leaving nothing
    send_alloc(24'd4);

    // best fit: exact fits, then a request that only one block can hold
    gaps_on = 1'b1;
    reconfigure(POL_BEST, 5'd16);
    send_alloc(24'd4);
    send_alloc(24'd6);
    send_alloc(24'd1);

    // worst fit with a count above the table size, tie goes to the lower block
    reconfigure(POL_WORST, 5'd31);
    send_load(4'd2, 24'd20);
    send_load(4'd5, 24'd20);
    send_alloc(24'd1);

    // next fit walks from the last grant
    reconfigure(POL_NEXT, 5'd16);
    send_load(4'd15, 24'd100);
    send_alloc(24'd50);
    // pointer now sits past the shrunk count, so the scan restarts at block 0
    reconfigure(POL_NEXT, 5'd6);
    send_alloc(24'd5);
    send_alloc(24'd5);

    // no blocks in use refuses even a zero request
    reconfigure(POL_FIRST, 5'd0);
    send_alloc('0);

    // single block
    reconfigure(POL_NEXT, 5'd1);
    send_alloc('0);
    send_alloc(24'd1);

    // random phases: each picks a setup, often refills the table, then mixes words
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0:       count = 5'd0;
        1:       count = 5'($urandom_range(17, 31));
        2:       count = 5'd1;
        3:       count = 5'd16;
        default: count = 5'($urandom_range(1, 16));
      endcase
      gaps_on = (phase % 4) != 1;  // some phases run back to back
      reconfigure(2'($urandom_range(0, 3)), count);
      if ($urandom_range(0, 2) != 0)
        for (int s = 0; s < BLOCKS; s++) send_load(SLOT_W'(s), draw_size(1'b1));
      for (int n = 0; n < 36; n++) begin
        // mid-run the receiver holds off while allocates keep coming
        if (phase == 2 && n == 4) hold_request = 1'b1;
        if ($urandom_range(0, 3) == 0 && !(phase == 2 && n >= 4 && n < 24))
          send_load(SLOT_W'($urandom_range(0, BLOCKS - 1)), draw_size(1'b1));
        else
          send_alloc(draw_size(1'b0));
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (grants_owed != 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("[fit_block_allocator_top] OK");
    else
      $display("[fit_block_allocator_top] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/fac_pkg.sv
sv/fac_cell.sv
sv/fit_block_allocator_top.sv
tb/sv/fit_block_allocator_checker.sv
tb/sv/fit_block_allocator_top_test.sv
